// ----- rtl/core/plist_pkg.sv -----
package plist_pkg;

	localparam int POS_W = 8;
	localparam int VAL_W = 32;

	localparam logic [1:0] FN_INSERT = 2'd0;
	localparam logic [1:0] FN_REMOVE = 2'd1;
	localparam logic [1:0] FN_CLEAR  = 2'd2;
	localparam logic [1:0] FN_READ   = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [POS_W-1:0] pos;
	} cell_ctrl_t;

endpackage

// ----- rtl/core/positional_list_insert_remove.sv -----
// Results are registered: an accepted request loads done, status, count and read_value into registers.
// Throughput: one request per cycle; busy stays low, the whole row of cells
// shifts in the accepting cycle, so the cell update sets the pace.
// Reset clears the count and the result strobe; cell contents are undefined.
// The receiver cannot stall: each result is shown for one cycle only.
module positional_list_insert_remove #(
	parameter int DEPTH = 16,
	localparam int CW = $clog2(DEPTH + 1),
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         func,
	input  logic [plist_pkg::POS_W-1:0]        position,
	input  logic signed [plist_pkg::VAL_W-1:0] value,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [CW-1:0]                      count,
	output logic signed [plist_pkg::VAL_W-1:0] read_value
);

	logic                               accept;
	logic [CW-1:0]                      len_q;
	logic [CW-1:0]                      len_next;
	logic [1:0]                         status_c;
	logic                               ins_ok;
	logic                               rem_ok;
	logic                               read_ok;
	plist_pkg::cell_ctrl_t              cell_ctrl;
	logic signed [plist_pkg::VAL_W-1:0] cell_data [DEPTH];
	logic [plist_pkg::POS_W-1:0]        pos_m1;
	logic [AW-1:0]                      rd_idx;
	logic                               done_q;
	logic [1:0]                         status_q;
	logic signed [plist_pkg::VAL_W-1:0] read_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	plist_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.func     (func),
		.position (position),
		.len      (len_q),
		.status   (status_c),
		.len_next (len_next),
		.ins_ok   (ins_ok),
		.rem_ok   (rem_ok),
		.read_ok  (read_ok)
	);

	assign cell_ctrl.ins = accept && ins_ok;
	assign cell_ctrl.rem = accept && rem_ok;
	assign cell_ctrl.pos = position;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		plist_cell #(.IDX(i)) u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl),
			.ins_value  (value),
			.from_lower ((i == 0) ? value : cell_data[(i == 0) ? 0 : i - 1]),
			.from_upper ((i == DEPTH - 1) ? cell_data[i]
				: cell_data[(i == DEPTH - 1) ? i : i + 1]),
			.data       (cell_data[i])
		);
	end

	// position is in range whenever read_ok is set
	assign pos_m1 = position - 1'b1;
	assign rd_idx = pos_m1[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			done_q   <= 1'b0;
			status_q <= plist_pkg::ST_OK;
			read_q   <= '0;
		end else begin
			done_q <= accept;
			if (accept) begin
				len_q    <= len_next;
				status_q <= status_c;
				read_q   <= read_ok ? cell_data[rd_idx] : '0;
			end
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign count      = len_q;
	assign read_value = read_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted beat gave no result");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CW'(DEPTH))
		else $error("count above depth");

	a_err_keeps_len: assert property (@(posedge clk) disable iff (!arst_n)
		accept && status_c != plist_pkg::ST_OK |=> len_q == $past(len_q))
		else $error("count changed on an error");

	a_err_zero_read: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != plist_pkg::ST_OK |-> read_value == '0)
		else $error("nonzero read value on an error");

	a_one_shift: assert property (@(posedge clk) disable iff (!arst_n)
		!(cell_ctrl.ins && cell_ctrl.rem))
		else $error("insert and remove shift together");

endmodule

// ----- rtl/core/plist_cell.sv -----
module plist_cell #(
	parameter int IDX = 0
) (
	input  logic                             clk,
	input  plist_pkg::cell_ctrl_t            ctrl,
	input  logic signed [plist_pkg::VAL_W-1:0] ins_value,
	input  logic signed [plist_pkg::VAL_W-1:0] from_lower,
	input  logic signed [plist_pkg::VAL_W-1:0] from_upper,
	output logic signed [plist_pkg::VAL_W-1:0] data
);

	// 1-based slot number of this cell
	localparam logic [plist_pkg::POS_W-1:0] SLOT = plist_pkg::POS_W'(IDX + 1);

	logic signed [plist_pkg::VAL_W-1:0] data_q;

	always_ff @(posedge clk) begin
		priority if (ctrl.ins && ctrl.pos == SLOT) begin
			data_q <= ins_value;
		end else if (ctrl.ins && SLOT > ctrl.pos) begin
			data_q <= from_lower;
		end else if (ctrl.rem && SLOT >= ctrl.pos) begin
			data_q <= from_upper;
		end
	end

	assign data = data_q;

endmodule

// ----- rtl/core/plist_ctrl.sv -----
module plist_ctrl #(
	parameter int DEPTH = 16,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic [1:0]                  func,
	input  logic [plist_pkg::POS_W-1:0] position,
	input  logic [CW-1:0]               len,
	output logic [1:0]                  status,
	output logic [CW-1:0]               len_next,
	output logic                        ins_ok,
	output logic                        rem_ok,
	output logic                        read_ok
);

	logic [plist_pkg::POS_W:0] pos_x;
	logic [plist_pkg::POS_W:0] len_x;
	logic                      full;
	logic                      empty;
	logic                      pos_zero;

	assign pos_x    = {1'b0, position};
	assign len_x    = (plist_pkg::POS_W + 1)'(len);
	assign full     = len_x >= (plist_pkg::POS_W + 1)'(DEPTH);
	assign empty    = len == '0;
	assign pos_zero = position == '0;

	always_comb begin
		status   = plist_pkg::ST_OK;
		len_next = len;
		ins_ok   = 1'b0;
		rem_ok   = 1'b0;
		read_ok  = 1'b0;
		unique case (func)
			plist_pkg::FN_INSERT: begin
				priority if (full) begin
					status = plist_pkg::ST_FULL;
				end else if (pos_zero || pos_x > len_x + 1'b1) begin
					status = plist_pkg::ST_INVALID;
				end else begin
					ins_ok   = 1'b1;
					len_next = len + 1'b1;
				end
			end
			plist_pkg::FN_REMOVE: begin
				priority if (empty) begin
					status = plist_pkg::ST_EMPTY;
				end else if (pos_zero || pos_x > len_x) begin
					status = plist_pkg::ST_INVALID;
				end else begin
					rem_ok   = 1'b1;
					len_next = len - 1'b1;
				end
			end
			plist_pkg::FN_CLEAR: begin
				len_next = '0;
			end
			plist_pkg::FN_READ: begin
				if (pos_zero || pos_x > len_x) begin
					status = plist_pkg::ST_INVALID;
				end else begin
					read_ok = 1'b1;
				end
			end
			default: begin
				status = plist_pkg::ST_INVALID;
			end
		endcase
	end

endmodule

// ----- tb/sv/positional_list_insert_remove_tb.sv -----
module positional_list_insert_remove_tb;

	localparam int LIST_DEPTH  = 16;
	localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
	localparam int QUIET_LIMIT = 1000;
	localparam int RAND_ITEMS  = 1434;

	typedef struct {
		logic [1:0]                  fn;
		logic [plist_pkg::POS_W-1:0] pos;
		logic [plist_pkg::VAL_W-1:0] val;
		int                          gap;
	} list_req_t;

	typedef struct {
		logic [1:0]                  status;
		logic [CNT_W-1:0]            cnt;
		logic [plist_pkg::VAL_W-1:0] rd;
	} list_result_t;

	logic                               clk;
	logic                               arst_n;
	logic                               start;
	logic                               busy;
	logic [1:0]                         func;
	logic [plist_pkg::POS_W-1:0]        position;
	logic signed [plist_pkg::VAL_W-1:0] value;
	logic                               done;
	logic [1:0]                         status;
	logic [CNT_W-1:0]                   count;
	logic signed [plist_pkg::VAL_W-1:0] read_value;

	list_req_t    req_q[$];
	list_result_t outcome_q[$];
	list_req_t    cur_req;
	list_result_t got_exp;
	logic [plist_pkg::VAL_W-1:0] cells[LIST_DEPTH];
	int           list_len;
	int           n_total;
	int           n_accepted;
	int           fail_cnt;
	int           quiet_cycles;
	bit           fire;

	positional_list_insert_remove #(.DEPTH(LIST_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.position(position),
		.value(value),
		.done(done),
		.status(status),
		.count(count),
		.read_value(read_value)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Apply one request to the shadow list and return what the block should report.
	function automatic list_result_t list_apply(input list_req_t r);
		list_result_t res;
		int i;
		res.status = plist_pkg::ST_OK;
		res.rd = '0;
		case (r.fn)
			plist_pkg::FN_INSERT: begin
				if (list_len >= LIST_DEPTH)
					res.status = plist_pkg::ST_FULL;
				else if (r.pos == 0 || r.pos > list_len + 1)
					res.status = plist_pkg::ST_INVALID;
				else begin
					for (i = list_len; i >= r.pos; i--)
						cells[i] = cells[i-1];
					cells[r.pos-1] = r.val;
					list_len++;
				end
			end
			plist_pkg::FN_REMOVE: begin
				if (list_len == 0)
					res.status = plist_pkg::ST_EMPTY;
				else if (r.pos == 0 || r.pos > list_len)
					res.status = plist_pkg::ST_INVALID;
				else begin
					for (i = r.pos - 1; i + 1 < list_len; i++)
						cells[i] = cells[i+1];
					list_len--;
				end
			end
			plist_pkg::FN_CLEAR: begin
				list_len = 0;
			end
			default: begin
				if (r.pos == 0 || r.pos > list_len)
					res.status = plist_pkg::ST_INVALID;
				else
					res.rd = cells[r.pos-1];
			end
		endcase
		res.cnt = list_len[CNT_W-1:0];
		return res;
	endfunction

	task automatic add_req(input logic [1:0] fn, input int pos,
			input logic [plist_pkg::VAL_W-1:0] val, input int gap);
		list_req_t r;
		r.fn = fn;
		r.pos = pos[plist_pkg::POS_W-1:0];
		r.val = val;
		r.gap = gap;
		req_q.push_back(r);
		n_total++;
	endtask

	// Driver: present one beat at a time, hold it until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			func <= plist_pkg::FN_CLEAR;
			position <= '0;
			value <= '0;
		end else begin
			fire = start && !busy;
			if (fire) begin
				outcome_q.push_back(list_apply(cur_req));
				n_accepted++;
			end
			if (fire || !start) begin
				if (req_q.size() > 0 && $urandom_range(99) >= req_q[0].gap) begin
					cur_req = req_q.pop_front();
					start <= 1'b1;
					func <= cur_req.fn;
					position <= cur_req.pos;
					value <= cur_req.val;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every done beat must match the oldest outstanding prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			if (done) begin
				if (outcome_q.size() == 0) begin
					if (fail_cnt < 10)
						$display("unexpected result beat: status %0d count %0d read_value %h",
							status, count, read_value);
					fail_cnt++;
				end else begin
					got_exp = outcome_q.pop_front();
					if (status !== got_exp.status || count !== got_exp.cnt ||
							read_value !== got_exp.rd) begin
						if (fail_cnt < 10)
							$display("mismatch: status %0d/%0d count %0d/%0d read_value %h/%h",
								got_exp.status, status, got_exp.cnt, count,
								got_exp.rd, read_value);
						fail_cnt++;
					end
				end
			end
			if (done || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int mode;
		int shadow_len;
		int gap;
		int p;
		int q;
		int pos;
		logic [1:0] fn;
		logic [plist_pkg::VAL_W-1:0] val;

		arst_n = 1'b0;
		n_total = 0;
		n_accepted = 0;
		fail_cnt = 0;
		list_len = 0;
		mode = 0;
		shadow_len = 0;

		// Directed: error order on an empty list, extremes, shifts, clear.
		add_req(plist_pkg::FN_READ, 1, '0, 0);
		add_req(plist_pkg::FN_REMOVE, 0, '0, 0);
		add_req(plist_pkg::FN_INSERT, 0, 32'h1234_5678, 0);
		add_req(plist_pkg::FN_INSERT, 2, 32'h1234_5678, 0);
		add_req(plist_pkg::FN_INSERT, 1, 32'h7fff_ffff, 0);
		add_req(plist_pkg::FN_INSERT, 2, 32'h8000_0000, 0);
		add_req(plist_pkg::FN_INSERT, 1, 32'hffff_ffff, 0);
		add_req(plist_pkg::FN_INSERT, 2, 32'h0000_0000, 0);
		add_req(plist_pkg::FN_READ, 0, 32'hffff_ffff, 0);
		add_req(plist_pkg::FN_READ, 4, '0, 0);
		add_req(plist_pkg::FN_READ, 5, '0, 0);
		add_req(plist_pkg::FN_READ, 255, '0, 0);
		add_req(plist_pkg::FN_REMOVE, 255, '0, 0);
		add_req(plist_pkg::FN_REMOVE, 2, '0, 0);
		add_req(plist_pkg::FN_READ, 2, '0, 0);
		add_req(plist_pkg::FN_REMOVE, 3, '0, 0);
		add_req(plist_pkg::FN_READ, 2, '0, 0);
		add_req(plist_pkg::FN_CLEAR, 0, 32'hffff_ffff, 0);
		add_req(plist_pkg::FN_READ, 1, '0, 0);
		add_req(plist_pkg::FN_CLEAR, 255, '0, 0);

		// Random: runs of growth, shrinkage and mixed traffic so the list hits full and empty.
		for (int k = 0; k < RAND_ITEMS; k++) begin
			if (k % 40 == 0)
				mode = $urandom_range(2);
			gap = (k < 360) ? 0 : (k < 720) ? 75 : (k < 1080) ? 24 : 0;
			p = $urandom_range(99);
			case (mode)
				0: fn = (p < 60) ? plist_pkg::FN_INSERT : (p < 75) ? plist_pkg::FN_REMOVE :
					(p < 97) ? plist_pkg::FN_READ : plist_pkg::FN_CLEAR;
				1: fn = (p < 15) ? plist_pkg::FN_INSERT : (p < 75) ? plist_pkg::FN_REMOVE :
					(p < 97) ? plist_pkg::FN_READ : plist_pkg::FN_CLEAR;
				default: fn = (p < 35) ? plist_pkg::FN_INSERT :
					(p < 65) ? plist_pkg::FN_REMOVE :
					(p < 97) ? plist_pkg::FN_READ : plist_pkg::FN_CLEAR;
			endcase
			q = $urandom_range(99);
			if (q < 80)
				pos = (fn == plist_pkg::FN_INSERT) ? $urandom_range(shadow_len + 1, 1) :
					$urandom_range((shadow_len > 0) ? shadow_len : 1, 1);
			else if (q < 88)
				pos = 0;
			else if (q < 94)
				pos = $urandom_range(shadow_len + 2, shadow_len + 1);
			else
				pos = $urandom_range(255);
			q = $urandom_range(99);
			if (q < 90)
				val = $urandom;
			else if (q < 95)
				val = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
			else
				val = $urandom_range(3) - 1;
			add_req(fn, pos, val, gap);
			// Track the length only to steer the position choice.
			if (fn == plist_pkg::FN_INSERT && shadow_len < LIST_DEPTH && pos >= 1 &&
					pos <= shadow_len + 1)
				shadow_len++;
			else if (fn == plist_pkg::FN_REMOVE && shadow_len > 0 && pos >= 1 &&
					pos <= shadow_len)
				shadow_len--;
			else if (fn == plist_pkg::FN_CLEAR)
				shadow_len = 0;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (!(n_accepted == n_total && outcome_q.size() == 0))
			@(posedge clk);
		repeat (3) @(posedge clk);

		if (fail_cnt == 0 && outcome_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
